### design/gdf_pkg.sv
// Package: shared constants, command/status structs, controller states and the exp table.
package gdf_pkg;

	// Widths of the transaction fields
	localparam int VALUE_W    = 16;
	localparam int DIFF_W     = VALUE_W + 1;
	localparam int SQ_W       = 2 * DIFF_W;
	localparam int SUM_W      = 40;
	localparam int INV_W      = 24;
	localparam int PEAK_W     = 16;
	localparam int FIT_W      = 16;
	localparam int INDEX_W    = 16;
	localparam int CFG_ADDR_W = 8;
	localparam int CFG_DATA_W = 24;

	// Configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] CFG_INV_TWO_WIDTH_SQ = CFG_ADDR_W'(0);
	localparam logic [CFG_ADDR_W-1:0] CFG_PEAK_FITNESS     = CFG_ADDR_W'(1);
	localparam logic [INV_W-1:0]      INV_RESET            = INV_W'(32768);
	localparam logic [PEAK_W-1:0]     PEAK_RESET           = PEAK_W'(4096);

	// Population wrap point of the individual counter
	localparam int MAX_POPULATION = 65536;

	// Exponent argument x is Q24.40 (64 bits); table covers x in [0,16).
	// EXP_TABLE_DEPTH must be a power of two between 32 and 4096.
	localparam int X_W             = 64;
	localparam int X_INT_TOP       = 44;
	localparam int EXP_TABLE_DEPTH = 256;
	localparam int TAB_IDX_W       = $clog2(EXP_TABLE_DEPTH);
	localparam int TAB_ADDR_W      = TAB_IDX_W + 1;
	localparam int FRAC_W          = 16;
	localparam int ENTRY_W         = 31;
	localparam int INTERP_W        = ENTRY_W + FRAC_W;
	localparam int SCALED_W        = ENTRY_W + PEAK_W + 1;
	localparam int ROUND_SHIFT     = 30;
	localparam int TAYLOR_TERMS    = 12;

	typedef logic [ENTRY_W-1:0] exp_tab_t [EXP_TABLE_DEPTH+1];

	// Build exp(-k*s) in Q1.30 with r = exp(-s) from a truncated Taylor series
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t   tab;
		logic [63:0] step;
		logic [63:0] term;
		logic [63:0] acc;
		logic [63:0] prod;
		step = (64'd16 << 32) / 64'(EXP_TABLE_DEPTH);
		term = 64'd1 << 32;
		acc  = term;
		for (int k = 1; k <= TAYLOR_TERMS; k++) begin
			term = ((term * step) >> 32) / 64'(k);
			if (k % 2 == 1) begin
				acc = (acc >= term) ? acc - term : 64'd0;
			end else begin
				acc = acc + term;
			end
		end
		if (acc > 64'hFFFF_FFFF) begin
			acc = 64'hFFFF_FFFF;
		end
		tab[0] = ENTRY_W'(64'd1 << 30);
		for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
			prod       = (64'(tab[i]) * acc) >> 32;
			tab[i + 1] = prod[ENTRY_W-1:0];
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ACCUM,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_ADD,
		ST_LOOKUP,
		ST_INTERP,
		ST_SUBTRACT,
		ST_SCALE,
		ST_EMIT
	} gdf_state_t;

	typedef struct packed {
		logic capture;
		logic square;
		logic accumulate;
		logic mul_lo;
		logic mul_hi;
		logic add;
		logic lookup;
		logic interp;
		logic subtract;
		logic scale;
		logic emit;
	} gdf_cmd_t;

	typedef struct packed {
		logic last_component;
	} gdf_status_t;

endpackage

### design/gdf_in_if.sv
// Interface: input item channel (one trait component per transaction).
interface gdf_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [gdf_pkg::VALUE_W-1:0] trait_value;
	logic signed [gdf_pkg::VALUE_W-1:0] optimum_value;
	logic                              last_component;
	logic                              last_individual;

	modport source (
		output valid, trait_value, optimum_value, last_component, last_individual,
		input  ready
	);
	modport sink (
		input  valid, trait_value, optimum_value, last_component, last_individual,
		output ready
	);
endinterface

### design/gdf_out_if.sv
// Interface: result channel (one fitness per individual).
interface gdf_out_if;
	logic                              valid;
	logic                              ready;
	logic [gdf_pkg::FIT_W-1:0]         fitness_value;
	logic [gdf_pkg::INDEX_W-1:0]       individual_index;
	logic                              pass_done;

	modport source (
		output valid, fitness_value, individual_index, pass_done,
		input  ready
	);
	modport sink (
		input  valid, fitness_value, individual_index, pass_done,
		output ready
	);
endinterface

### design/gdf_cfg_if.sv
// Interface: configuration register write channel.
interface gdf_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [gdf_pkg::CFG_ADDR_W-1:0]    index;
	logic [gdf_pkg::CFG_DATA_W-1:0]    data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

### design/gaussian_distance_fitness_unit.sv
// Top level: Gaussian distance fitness unit, controller plus datapath.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+--------------------------------------------------
//  item    | in  | valid / ready | trait_value, optimum_value, last_component,
//          |     |               | last_individual
//  result  | out | valid / ready | fitness_value, individual_index, pass_done
//  cfg     | in  | valid / ready | index (0: inv_two_width_sq, 1: peak_fitness), data
//
// A component that does not close an individual passes capture, square and
// accumulate; the closing component goes on through the split 40x24 argument
// multiply (low, high, add), lookup, interpolate, subtract, scale and emit.
// A finished result waits in the output register while the next items are taken;
// the controller only stalls in its emit step while that register is still full.
// arst_n clears the sequencer, the running sum, the individual counter and resets
// the configuration registers to their defaults. cfg is always ready.
module gaussian_distance_fitness_unit (
	input  logic       clk,
	input  logic       arst_n,
	gdf_in_if.sink     item,
	gdf_out_if.source  result,
	gdf_cfg_if.sink    cfg
);

	gdf_pkg::gdf_cmd_t    cmd;
	gdf_pkg::gdf_status_t status;

	// Configuration writes are never held off; nothing to arbitrate
	assign cfg.ready = 1'b1;

	// Sequence capture, accumulate and the fitness evaluation
	gdf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.result_ready (result.ready),
		.result_valid (result.valid),
		.status       (status),
		.cmd          (cmd)
	);

	// Arithmetic, configuration registers and output payload
	gdf_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.trait_value      (item.trait_value),
		.optimum_value    (item.optimum_value),
		.last_component   (item.last_component),
		.last_individual  (item.last_individual),
		.cfg_write        (cfg.valid),
		.cfg_index        (cfg.index),
		.cfg_data         (cfg.data),
		.fitness_value    (result.fitness_value),
		.individual_index (result.individual_index),
		.pass_done        (result.pass_done)
	);

endmodule

### design/gdf_ctrl.sv
// Controller: sequences one item through the datapath and owns the result valid.
module gdf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  logic                 result_ready,
	output logic                 result_valid,
	input  gdf_pkg::gdf_status_t status,
	output gdf_pkg::gdf_cmd_t    cmd
);

	gdf_pkg::gdf_state_t state_q;
	gdf_pkg::gdf_state_t state_next;
	logic                out_valid_q;
	logic                out_free;

	assign out_free     = !out_valid_q || result_ready;
	assign result_valid = out_valid_q;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			gdf_pkg::ST_IDLE: begin
				if (item_valid) state_next = gdf_pkg::ST_SQUARE;
			end
			gdf_pkg::ST_SQUARE:   state_next = gdf_pkg::ST_ACCUM;
			gdf_pkg::ST_ACCUM: begin
				state_next = status.last_component ? gdf_pkg::ST_MUL_LO : gdf_pkg::ST_IDLE;
			end
			gdf_pkg::ST_MUL_LO:   state_next = gdf_pkg::ST_MUL_HI;
			gdf_pkg::ST_MUL_HI:   state_next = gdf_pkg::ST_ADD;
			gdf_pkg::ST_ADD:      state_next = gdf_pkg::ST_LOOKUP;
			gdf_pkg::ST_LOOKUP:   state_next = gdf_pkg::ST_INTERP;
			gdf_pkg::ST_INTERP:   state_next = gdf_pkg::ST_SUBTRACT;
			gdf_pkg::ST_SUBTRACT: state_next = gdf_pkg::ST_SCALE;
			gdf_pkg::ST_SCALE:    state_next = gdf_pkg::ST_EMIT;
			gdf_pkg::ST_EMIT: begin
				if (out_free) state_next = gdf_pkg::ST_IDLE;
			end
			default:              state_next = gdf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			gdf_pkg::ST_IDLE: begin
				item_ready  = 1'b1;
				cmd.capture = item_valid;
			end
			gdf_pkg::ST_SQUARE:   cmd.square     = 1'b1;
			gdf_pkg::ST_ACCUM:    cmd.accumulate = 1'b1;
			gdf_pkg::ST_MUL_LO:   cmd.mul_lo     = 1'b1;
			gdf_pkg::ST_MUL_HI:   cmd.mul_hi     = 1'b1;
			gdf_pkg::ST_ADD:      cmd.add        = 1'b1;
			gdf_pkg::ST_LOOKUP:   cmd.lookup     = 1'b1;
			gdf_pkg::ST_INTERP:   cmd.interp     = 1'b1;
			gdf_pkg::ST_SUBTRACT: cmd.subtract   = 1'b1;
			gdf_pkg::ST_SCALE:    cmd.scale      = 1'b1;
			gdf_pkg::ST_EMIT:     cmd.emit       = out_free;
			default:              cmd            = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gdf_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			// Hold the result until taken; a new result may load as the old one leaves
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### design/gdf_datapath.sv
// Datapath: distance accumulator, split argument multiply, exp table interpolation, scaling.
module gdf_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  gdf_pkg::gdf_cmd_t                    cmd,
	output gdf_pkg::gdf_status_t                 status,
	input  logic signed [gdf_pkg::VALUE_W-1:0]   trait_value,
	input  logic signed [gdf_pkg::VALUE_W-1:0]   optimum_value,
	input  logic                                 last_component,
	input  logic                                 last_individual,
	input  logic                                 cfg_write,
	input  logic [gdf_pkg::CFG_ADDR_W-1:0]       cfg_index,
	input  logic [gdf_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic [gdf_pkg::FIT_W-1:0]            fitness_value,
	output logic [gdf_pkg::INDEX_W-1:0]          individual_index,
	output logic                                 pass_done
);

	localparam int IDX_LSB  = gdf_pkg::X_INT_TOP - gdf_pkg::TAB_IDX_W;
	localparam int FRAC_LSB = IDX_LSB - gdf_pkg::FRAC_W;
	localparam int LO_W     = gdf_pkg::INV_W;
	localparam int HI_W     = gdf_pkg::SUM_W - LO_W;
	localparam int ROUND_SH = gdf_pkg::ROUND_SHIFT;

	// Control state
	logic [gdf_pkg::INV_W-1:0]   inv_q;
	logic [gdf_pkg::PEAK_W-1:0]  peak_q;
	logic [gdf_pkg::SUM_W-1:0]   sum_q;
	logic [gdf_pkg::INDEX_W-1:0] count_q;
	logic                        last_comp_q;

	// Payload registers
	logic signed [gdf_pkg::DIFF_W-1:0] diff_q;
	logic                              last_ind_q;
	logic [gdf_pkg::SQ_W-1:0]          sq_q;
	logic [gdf_pkg::SUM_W-1:0]         arg_q;
	logic [LO_W+gdf_pkg::INV_W-1:0]    plo_q;
	logic [HI_W+gdf_pkg::INV_W-1:0]    phi_q;
	logic [gdf_pkg::X_W-1:0]           x_q;
	logic                              zero_q;
	logic [gdf_pkg::ENTRY_W-1:0]       hi_q;
	logic [gdf_pkg::ENTRY_W-1:0]       lo_q;
	logic [gdf_pkg::FRAC_W-1:0]        frac_q;
	logic [gdf_pkg::INTERP_W-1:0]      prod_q;
	logic [gdf_pkg::ENTRY_W-1:0]       e_q;
	logic [gdf_pkg::SCALED_W-1:0]      scaled_q;
	logic [gdf_pkg::FIT_W-1:0]         fit_q;
	logic [gdf_pkg::INDEX_W-1:0]       index_q;
	logic                              pass_q;

	logic signed [gdf_pkg::SQ_W-1:0]   sq_full;
	logic [gdf_pkg::SUM_W:0]           sum_wide;
	logic [gdf_pkg::SUM_W-1:0]         sum_sat;
	logic [gdf_pkg::TAB_IDX_W-1:0]     tab_idx;
	logic [gdf_pkg::TAB_ADDR_W-1:0]    tab_addr_lo;
	logic [gdf_pkg::SCALED_W-ROUND_SH-1:0] fit_raw;
	logic [gdf_pkg::INDEX_W:0]         count_inc;
	logic [gdf_pkg::INDEX_W-1:0]       count_next;

	assign status.last_component = last_comp_q;

	assign sq_full  = diff_q * diff_q;
	assign sum_wide = {1'b0, sum_q} + (gdf_pkg::SUM_W+1)'(sq_q);
	// Saturate the distance at all ones
	assign sum_sat  = sum_wide[gdf_pkg::SUM_W] ? '1 : sum_wide[gdf_pkg::SUM_W-1:0];

	assign tab_idx     = x_q[gdf_pkg::X_INT_TOP-1:IDX_LSB];
	assign tab_addr_lo = {1'b0, tab_idx} + gdf_pkg::TAB_ADDR_W'(1);

	assign fit_raw = scaled_q[gdf_pkg::SCALED_W-1:ROUND_SH];

	assign count_inc  = {1'b0, count_q} + (gdf_pkg::INDEX_W+1)'(1);
	assign count_next = (last_ind_q || 32'(count_inc) >= gdf_pkg::MAX_POPULATION
		|| count_inc[gdf_pkg::INDEX_W]) ? '0 : count_inc[gdf_pkg::INDEX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q       <= gdf_pkg::INV_RESET;
			peak_q      <= gdf_pkg::PEAK_RESET;
			sum_q       <= '0;
			count_q     <= '0;
			last_comp_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					gdf_pkg::CFG_INV_TWO_WIDTH_SQ: inv_q  <= cfg_data[gdf_pkg::INV_W-1:0];
					gdf_pkg::CFG_PEAK_FITNESS:     peak_q <= cfg_data[gdf_pkg::PEAK_W-1:0];
					default: ;
				endcase
			end
			if (cmd.capture) begin
				last_comp_q <= last_component;
			end
			if (cmd.accumulate) begin
				// Clear the sum when the individual closes
				sum_q <= last_comp_q ? '0 : sum_sat;
			end
			if (cmd.emit) begin
				count_q <= count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			diff_q     <= gdf_pkg::DIFF_W'(optimum_value) - gdf_pkg::DIFF_W'(trait_value);
			last_ind_q <= last_individual;
		end
		if (cmd.square) begin
			sq_q <= sq_full;
		end
		if (cmd.accumulate) begin
			arg_q <= sum_sat;
		end
		if (cmd.mul_lo) begin
			plo_q <= arg_q[LO_W-1:0] * inv_q;
		end
		if (cmd.mul_hi) begin
			phi_q <= arg_q[gdf_pkg::SUM_W-1:LO_W] * inv_q;
		end
		if (cmd.add) begin
			x_q <= gdf_pkg::X_W'(plo_q) + (gdf_pkg::X_W'(phi_q) << LO_W);
		end
		if (cmd.lookup) begin
			zero_q <= |x_q[gdf_pkg::X_W-1:gdf_pkg::X_INT_TOP];
			hi_q   <= gdf_pkg::EXP_TAB[tab_idx];
			lo_q   <= gdf_pkg::EXP_TAB[tab_addr_lo];
			frac_q <= x_q[IDX_LSB-1:FRAC_LSB];
		end
		if (cmd.interp) begin
			prod_q <= (hi_q - lo_q) * frac_q;
		end
		if (cmd.subtract) begin
			e_q <= hi_q - prod_q[gdf_pkg::INTERP_W-1:gdf_pkg::FRAC_W];
		end
		if (cmd.scale) begin
			scaled_q <= gdf_pkg::SCALED_W'(e_q * peak_q)
				+ (gdf_pkg::SCALED_W'(1) << (ROUND_SH - 1));
		end
		if (cmd.emit) begin
			if (zero_q) begin
				fit_q <= '0;
			end else if (|fit_raw[$bits(fit_raw)-1:gdf_pkg::FIT_W]) begin
				fit_q <= '1;
			end else begin
				fit_q <= fit_raw[gdf_pkg::FIT_W-1:0];
			end
			index_q <= count_q;
			pass_q  <= last_ind_q;
		end
	end

	assign fitness_value    = fit_q;
	assign individual_index = index_q;
	assign pass_done        = pass_q;

endmodule

### design/gdf_checker.sv
// Checker: port-level assertions on the fitness unit, attached by bind.
module gdf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          item_valid,
	input logic                          item_ready,
	input logic                          item_last_component,
	input logic                          result_valid,
	input logic                          result_ready,
	input logic [gdf_pkg::FIT_W-1:0]     fitness_value,
	input logic [gdf_pkg::INDEX_W-1:0]   individual_index,
	input logic                          pass_done
);

	// A stalled result stays offered
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(fitness_value)
			&& $stable(individual_index) && $stable(pass_done))
		else $error("result payload changed while stalled");

	// One item at a time: no transaction in the cycle after one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item taken while previous still in work");

	// A non-closing component frees the input after the square and accumulate steps
	a_accum_latency: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && !item_last_component |-> ##3 item_ready)
		else $error("accumulate step did not return to idle");

endmodule

bind gaussian_distance_fitness_unit gdf_checker u_gdf_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.item_valid          (item.valid),
	.item_ready          (item.ready),
	.item_last_component (item.last_component),
	.result_valid        (result.valid),
	.result_ready        (result.ready),
	.fitness_value       (result.fitness_value),
	.individual_index    (result.individual_index),
	.pass_done           (result.pass_done)
);

### verif/gdf_fitness_checker.sv
`timescale 1ns / 1ps
// Checker: predicts each Gaussian fitness result from the observed transactions and compares.
module gdf_fitness_checker (
	input  logic clk,
	input  logic arst_n,
	gdf_in_if    item,
	gdf_out_if   result,
	gdf_cfg_if   cfg,
	output int   mismatches,
	output int   pending,
	output int   items_seen,
	output int   results_seen,
	output int   clipped_sums
);
	localparam logic [63:0] SUM_CEIL  = (64'd1 << gdf_pkg::SUM_W) - 64'd1;
	localparam logic [63:0] ARG_CEIL  = 64'd16 << (gdf_pkg::X_INT_TOP - 4);
	localparam logic [63:0] HALF_LSB  = 64'd1 << (gdf_pkg::ROUND_SHIFT - 1);

	typedef struct packed {
		logic [gdf_pkg::FIT_W-1:0]   fitness_value;
		logic [gdf_pkg::INDEX_W-1:0] individual_index;
		logic                        pass_done;
	} fitness_rec_t;

	// exp(-k*step) in Q2.30, one row per table step
	logic [31:0]                 decay_lut [gdf_pkg::EXP_TABLE_DEPTH+1];
	logic [gdf_pkg::INV_W-1:0]   width_scale;
	logic [gdf_pkg::PEAK_W-1:0]  peak_scale;
	logic [gdf_pkg::SUM_W-1:0]   running_sq;
	logic [gdf_pkg::INDEX_W-1:0] slot;
	fitness_rec_t                due_fitness [$];

	initial begin
		logic [63:0] step_q;
		logic [63:0] term;
		logic [63:0] ratio;
		bit          subtract;
		step_q   = (64'd16 << 32) / 64'(gdf_pkg::EXP_TABLE_DEPTH);
		term     = 64'd1 << 32;
		ratio    = term;
		subtract = 1'b1;
		// exp(-step) by truncated Taylor terms, clamped at zero on the way down
		for (int k = 1; k <= gdf_pkg::TAYLOR_TERMS; k++) begin
			term = ((term * step_q) >> 32) / 64'(k);
			if (subtract)
				ratio = (ratio >= term) ? ratio - term : 64'd0;
			else
				ratio = ratio + term;
			subtract = !subtract;
		end
		if (ratio > 64'hFFFF_FFFF)
			ratio = 64'hFFFF_FFFF;
		decay_lut[0] = 32'd1 << 30;
		for (int i = 1; i <= gdf_pkg::EXP_TABLE_DEPTH; i++)
			decay_lut[i] = 32'((64'(decay_lut[i-1]) * ratio) >> 32);
	end

	function automatic logic [gdf_pkg::FIT_W-1:0] gaussian_fitness(logic [63:0] arg,
			logic [gdf_pkg::PEAK_W-1:0] peak);
		logic [63:0] pos;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [63:0] e;
		logic [63:0] f;
		int          row;
		if (arg >= ARG_CEIL)
			return '0;
		pos = arg * 64'(gdf_pkg::EXP_TABLE_DEPTH);
		row = int'(pos >> gdf_pkg::X_INT_TOP);
		if (row >= gdf_pkg::EXP_TABLE_DEPTH)
			return '0;
		hi = 64'(decay_lut[row]);
		lo = 64'(decay_lut[row + 1]);
		e  = hi - (((hi - lo) * 64'(pos[gdf_pkg::X_INT_TOP-1 -: gdf_pkg::FRAC_W]))
			>> gdf_pkg::FRAC_W);
		f  = (e * 64'(peak) + HALF_LSB) >> gdf_pkg::ROUND_SHIFT;
		return (f > 64'hFFFF) ? '1 : f[gdf_pkg::FIT_W-1:0];
	endfunction

	task automatic flag_mismatch(string what);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t ns mismatch: %s", $time, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		int           diff;
		int           next_slot;
		logic [63:0]  total;
		fitness_rec_t due;
		fitness_rec_t seen;
		if (!arst_n) begin
			width_scale  = gdf_pkg::INV_RESET;
			peak_scale   = gdf_pkg::PEAK_RESET;
			running_sq   = '0;
			slot         = '0;
			mismatches   = 0;
			pending      = 0;
			items_seen   = 0;
			results_seen = 0;
			clipped_sums = 0;
			due_fitness.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					gdf_pkg::CFG_INV_TWO_WIDTH_SQ:
						width_scale = cfg.data[gdf_pkg::INV_W-1:0];
					gdf_pkg::CFG_PEAK_FITNESS:
						peak_scale  = cfg.data[gdf_pkg::PEAK_W-1:0];
					default: ;
				endcase
			end
			if (item.valid && item.ready) begin
				items_seen++;
				diff = int'(item.optimum_value) - int'(item.trait_value);
				if (diff < 0)
					diff = -diff;
				total = 64'(running_sq) + 64'(diff) * 64'(diff);
				if (total > SUM_CEIL) begin
					total = SUM_CEIL;
					clipped_sums++;
				end
				if (!item.last_component) begin
					running_sq = total[gdf_pkg::SUM_W-1:0];
				end else begin
					due.fitness_value    = gaussian_fitness(total * 64'(width_scale),
						peak_scale);
					due.individual_index = slot;
					due.pass_done        = item.last_individual;
					due_fitness.push_back(due);
					running_sq = '0;
					next_slot  = int'(slot) + 1;
					if (item.last_individual || next_slot >= gdf_pkg::MAX_POPULATION
							|| next_slot > 65535)
						slot = '0;
					else
						slot = gdf_pkg::INDEX_W'(next_slot);
				end
			end
			if (result.valid && result.ready) begin
				results_seen++;
				seen.fitness_value    = result.fitness_value;
				seen.individual_index = result.individual_index;
				seen.pass_done        = result.pass_done;
				if (due_fitness.size() == 0) begin
					flag_mismatch($sformatf("unexpected result fitness %0d index %0d pass_done %0d",
						seen.fitness_value, seen.individual_index, seen.pass_done));
				end else begin
					due = due_fitness.pop_front();
					if (seen.fitness_value !== due.fitness_value)
						flag_mismatch($sformatf("individual %0d fitness_value expected %0d got %0d",
							due.individual_index, due.fitness_value, seen.fitness_value));
					if (seen.individual_index !== due.individual_index)
						flag_mismatch($sformatf("individual_index expected %0d got %0d",
							due.individual_index, seen.individual_index));
					if (seen.pass_done !== due.pass_done)
						flag_mismatch($sformatf("individual %0d pass_done expected %0d got %0d",
							due.individual_index, due.pass_done, seen.pass_done));
				end
			end
			pending = due_fitness.size();
		end
	end

endmodule

### verif/tb_gaussian_distance_fitness_unit.sv
`timescale 1ns / 1ps
// Testbench top: drives items, result stalls and register writes, and reports the verdict.
module tb_gaussian_distance_fitness_unit;

	localparam int          RESET_CYCLES = 3;
	localparam int          MAX_GAP      = 16;
	// Closing component runs every step; leave room for the output register as well
	localparam int          SETTLE       = 40;
	localparam int          PHASE_ITEMS  = 75;
	// About 900 items under the longest gaps and stalls
	localparam int unsigned CYCLE_LIMIT  = 200_000;
	localparam logic [gdf_pkg::VALUE_W-1:0] Q_MIN = 16'h8000;
	localparam logic [gdf_pkg::VALUE_W-1:0] Q_MAX = 16'h7FFF;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	bit          steady_in;
	bit          steady_out;
	int unsigned cycle_count;
	int          items_sent;
	int          cfg_writes;
	int          mismatches;
	int          pending;
	int          items_seen;
	int          results_seen;
	int          clipped_sums;

	gdf_in_if  item ();
	gdf_out_if result ();
	gdf_cfg_if cfg ();

	gaussian_distance_fitness_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result),
		.cfg    (cfg)
	);

	// Checker watches all three channels and keeps the running prediction
	gdf_fitness_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.result       (result),
		.cfg          (cfg),
		.mismatches   (mismatches),
		.pending      (pending),
		.items_seen   (items_seen),
		.results_seen (results_seen),
		.clipped_sums (clipped_sums)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Watchdog: a hung handshake ends the run as a failure
	initial begin
		wait (cycle_count > CYCLE_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	// Result side: draw a stall per transaction, then hold ready until one is taken.
	// In steady stretches the stall is zero, so ready stays high back to back.
	initial begin
		int stall;
		result.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			stall = steady_out ? 0 : $urandom_range(0, MAX_GAP);
			if (stall != 0) begin
				result.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (!result.valid);
		end
	end

	// One item transaction. Entered and left at a falling edge; valid stays high on
	// return so that a zero gap gives back-to-back transactions.
	task automatic send_item(logic [gdf_pkg::VALUE_W-1:0] trait,
			logic [gdf_pkg::VALUE_W-1:0] opt, bit closes, bit ends_pass);
		int gap;
		gap = steady_in ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			item.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item.valid           <= 1'b1;
		item.trait_value     <= trait;
		item.optimum_value   <= opt;
		item.last_component  <= closes;
		item.last_individual <= ends_pass;
		do @(posedge clk); while (!item.ready);
		@(negedge clk);
		items_sent++;
	endtask

	// One individual: random traits, optimum offset by a per-individual distance scale
	// so that results land across the whole table, with some plain noise mixed in.
	// The pass flag on inner components must be dropped by the block.
	task automatic send_individual(int parts, bit ends_pass);
		int                          span;
		int                          delta;
		logic [gdf_pkg::VALUE_W-1:0] trait;
		logic [gdf_pkg::VALUE_W-1:0] opt;
		span = $urandom_range(0, 16);
		for (int n = 1; n <= parts; n++) begin
			trait = gdf_pkg::VALUE_W'($urandom_range(0, 16'hFFFF));
			delta = $urandom_range(0, (1 << span) - 1);
			opt   = ($urandom_range(0, 1) != 0) ? trait + gdf_pkg::VALUE_W'(delta)
				: trait - gdf_pkg::VALUE_W'(delta);
			if ($urandom_range(0, 7) == 0)
				opt = gdf_pkg::VALUE_W'($urandom_range(0, 16'hFFFF));
			send_item(trait, opt, n == parts,
				(n == parts) ? ends_pass : ($urandom_range(0, 5) == 0));
		end
	endtask

	// Widest differences on every component; 257 of them push the sum into saturation
	task automatic send_saturating(int parts);
		for (int n = 1; n <= parts; n++) begin
			if (n % 2 == 1)
				send_item(Q_MIN, Q_MAX, n == parts, 1'b0);
			else
				send_item(Q_MAX, Q_MIN, n == parts, 1'b0);
		end
	endtask

	// Random individuals until the phase has its share of items. Redraw the idle
	// mode now and then so that stretches without gaps or stalls show up.
	task automatic run_random(int count);
		int start;
		start = items_sent;
		while (items_sent - start < count) begin
			if ($urandom_range(0, 11) == 0) begin
				steady_in  = ($urandom_range(0, 2) == 0);
				steady_out = ($urandom_range(0, 2) == 0);
			end
			send_individual($urandom_range(1, ($urandom_range(0, 3) == 0) ? 12 : 4),
				$urandom_range(0, 9) == 0);
		end
	endtask

	// Drop valid, let every expected result drain, then give the pipeline time to
	// finish any open component that produces no result.
	task automatic settle();
		item.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// One register write; valid is left high for a following write in the series
	task automatic write_reg(logic [gdf_pkg::CFG_ADDR_W-1:0] idx,
			logic [gdf_pkg::CFG_DATA_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg_writes++;
	endtask

	// Write both registers, peak with junk in the unused upper data bits, and
	// optionally a write to an index past the register list, which must be ignored.
	task automatic apply_settings(logic [gdf_pkg::INV_W-1:0] inv,
			logic [gdf_pkg::PEAK_W-1:0] peak, bit stray);
		write_reg(gdf_pkg::CFG_INV_TWO_WIDTH_SQ, gdf_pkg::CFG_DATA_W'(inv));
		write_reg(gdf_pkg::CFG_PEAK_FITNESS,
			gdf_pkg::CFG_DATA_W'({8'($urandom_range(0, 255)), peak}));
		if (stray)
			write_reg(gdf_pkg::CFG_ADDR_W'($urandom_range(
				int'(gdf_pkg::CFG_PEAK_FITNESS) + 1, 255)),
				gdf_pkg::CFG_DATA_W'($urandom()));
		cfg.valid <= 1'b0;
	endtask

	// Directed opening under the reset settings (half scale, peak of one)
	task automatic run_directed();
		send_item(16'h0000, 16'h0000, 1'b1, 1'b0);  // zero distance: full peak
		send_item(Q_MAX, Q_MIN, 1'b1, 1'b0);        // widest difference, both signs
		send_item(Q_MIN, Q_MAX, 1'b1, 1'b0);
		send_item(Q_MAX, Q_MAX, 1'b1, 1'b1);        // end of pass: index restarts
		send_item(16'h1000, 16'h0000, 1'b0, 1'b1);  // pass flag on an inner component
		send_item(16'h0000, 16'h0800, 1'b1, 1'b0);
		send_item(16'h0000, 16'd23170, 1'b1, 1'b0); // argument just below the table end
		send_item(16'h0000, 16'd23171, 1'b1, 1'b0); // argument just past the table end
		send_item(16'd23171, 16'h0000, 1'b1, 1'b0);
		send_item(16'hFFFF, 16'h0001, 1'b0, 1'b0);  // three-component individual
		send_item(16'h0123, 16'hFEDC, 1'b0, 1'b0);
		send_item(16'h5555, 16'hAAAA, 1'b1, 1'b1);
		send_item(16'h0001, 16'h0000, 1'b1, 1'b0);  // one LSB of distance
		send_item(16'h4000, 16'h4001, 1'b1, 1'b0);
	endtask

	initial begin
		item.valid           = 1'b0;
		item.trait_value     = '0;
		item.optimum_value   = '0;
		item.last_component  = 1'b0;
		item.last_individual = 1'b0;
		cfg.valid            = 1'b0;
		cfg.index            = '0;
		cfg.data             = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: directed cases, then random individuals
		run_directed();
		run_random(PHASE_ITEMS);

		// Zero width factor: every fitness equals the peak, here the largest peak
		settle();
		apply_settings('0, '1, 1'b0);
		run_random(PHASE_ITEMS);

		// Largest width factor and zero peak, plus an ignored register index
		settle();
		apply_settings('1, '0, 1'b1);
		run_random(PHASE_ITEMS);

		// Smallest nonzero factor: a saturated sum still lands inside the table
		settle();
		apply_settings(gdf_pkg::INV_W'(1), '1, 1'b0);
		send_saturating(258);
		run_random(PHASE_ITEMS);

		// Both registers at their maximum
		settle();
		apply_settings('1, '1, 1'b1);
		run_random(PHASE_ITEMS);

		// Random settings, width factor spread over its magnitude range
		repeat (2) begin
			settle();
			apply_settings(gdf_pkg::INV_W'($urandom_range(0,
				(1 << $urandom_range(0, gdf_pkg::INV_W)) - 1)),
				gdf_pkg::PEAK_W'($urandom_range(0, 16'hFFFF)), 1'b1);
			run_random(PHASE_ITEMS);
		end

		// Back to the reset settings for a closing stretch
		settle();
		apply_settings(gdf_pkg::INV_RESET, gdf_pkg::PEAK_RESET, 1'b0);
		run_random(PHASE_ITEMS);

		settle();
		$display("Run covered %0d item and %0d result transactions with %0d register writes,",
			items_seen, results_seen, cfg_writes);
		$display("over extreme and random settings, %0d saturated sums and pass restarts.",
			clipped_sums);
		if (mismatches == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### files.f
design/gdf_pkg.sv
design/gdf_in_if.sv
design/gdf_out_if.sv
design/gdf_cfg_if.sv
design/gdf_ctrl.sv
design/gdf_datapath.sv
design/gaussian_distance_fitness_unit.sv
design/gdf_checker.sv
verif/gdf_fitness_checker.sv
verif/tb_gaussian_distance_fitness_unit.sv
